/* rtl/lqs_pkg.sv */
// shared types and constants of the linear queue with search
`default_nettype none

package lqs_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } lqs_state_t;

  // token that walks the cell chain: search key or picked-up head word
  typedef struct packed {
    logic              vld;
    logic              deq;
    logic              hit;
    logic [DATA_W-1:0] word;
  } tok_t;

endpackage

`default_nettype wire

/* rtl/linear_queue_with_search.sv */
// top level of the linear array queue with search
`default_nettype none

// Linear (non-wrapping) queue of DEPTH signed 32-bit words held in a row of
// cells, one slot per cell. Each input beat carries one operation: enqueue
// appends at the tail (status full once the tail sits in the last slot, even
// if slots below the head are free), dequeue removes the head word and
// returns it, search reports whether the key is among the stored words.
// Every input beat gives exactly one output beat. Enqueue, any operation on
// an empty queue and the unused code 3 are answered from the control logic:
// the result beat appears the cycle after acceptance. Dequeue and search on
// a non-empty queue launch a token into cell 0 that moves one cell per cycle
// down the chain; each cell compares or hands over its word as the token
// passes, and the result is registered once the token leaves the last cell;
// only then does the control return to idle. The block works on one item
// at a time; a new beat is taken only while idle and the output register is
// empty or being emptied in the same cycle.

module linear_queue_with_search
  import lqs_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic        [OP_W-1:0]     in_operation,
  input  wire logic signed [DATA_W-1:0]   in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [STATUS_W-1:0] out_status,
  output logic                            out_found,
  output logic signed      [DATA_W-1:0]   out_removed_value
);

  localparam int unsigned    AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0]  LAST = AW'(DEPTH - 1);

  // control state
  lqs_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]        out_status_r, out_status_nxt;
  logic                       out_found_r, out_found_nxt;
  logic signed [DATA_W-1:0]   out_removed_value_r, out_removed_value_nxt;

  // handshake and chain signals
  logic              accept;
  logic              needs_sweep;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  tok_t              tok_launch;
  tok_t              tok_chain [DEPTH+1];
  tok_t              tok_end;

  assign accept      = in_valid && in_ready;
  // dequeue and search on a stored queue go through the chain
  assign needs_sweep = ((in_operation == OP_DEQUEUE) || (in_operation == OP_SEARCH))
                       && !empty_r;
  assign tok_end     = tok_chain[DEPTH];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && needs_sweep) begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (tok_end.vld) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs: ready and token launch
  always_comb begin
    in_ready   = 1'b0;
    tok_launch = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready && needs_sweep) begin
          tok_launch.vld  = 1'b1;
          tok_launch.deq  = (in_operation == OP_DEQUEUE);
          tok_launch.word = $unsigned(in_value);
        end
      end
      S_SWEEP: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // slot write for enqueue; an empty queue restarts at slot 0
  assign wr_en   = accept && (in_operation == OP_ENQUEUE) && (empty_r || (tail_r != LAST));
  assign wr_addr = empty_r ? '0 : (tail_r + AW'(1));

  // queue positions and result register
  always_comb begin
    head_nxt              = head_r;
    tail_nxt              = tail_r;
    empty_nxt             = empty_r;
    out_valid_nxt         = out_valid_r && !out_ready;
    out_status_nxt        = out_status_r;
    out_found_nxt         = out_found_r;
    out_removed_value_nxt = out_removed_value_r;

    if (accept && !needs_sweep) begin
      out_valid_nxt         = 1'b1;
      out_status_nxt        = STATUS_DONE;
      out_found_nxt         = 1'b0;
      out_removed_value_nxt = '0;
      unique case (in_operation) inside
        OP_ENQUEUE: begin
          if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
          end else if (tail_r == LAST) begin
            out_status_nxt = STATUS_FULL;
          end else begin
            tail_nxt = tail_r + AW'(1);
          end
        end
        OP_DEQUEUE, OP_SEARCH: begin
          // only reached on an empty queue
          out_status_nxt = STATUS_EMPTY;
        end
        default: begin
          out_status_nxt = STATUS_DONE;
        end
      endcase
    end

    // token leaves the last cell: finish dequeue or search
    if (tok_end.vld) begin
      out_valid_nxt         = 1'b1;
      out_status_nxt        = STATUS_DONE;
      out_found_nxt         = !tok_end.deq && tok_end.hit;
      out_removed_value_nxt = tok_end.deq ? $signed(tok_end.word) : '0;
      if (tok_end.deq) begin
        if (head_r >= tail_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b1;
        end else begin
          head_nxt = head_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_status_r        <= out_status_nxt;
    out_found_r         <= out_found_nxt;
    out_removed_value_r <= out_removed_value_nxt;
  end

  // the cell chain: token enters cell 0 and leaves after cell DEPTH-1
  assign tok_chain[0] = tok_launch;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    lqs_cell #(
      .AW       (AW),
      .CELL_IDX (AW'(g))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(in_value)),
      .head    (head_r),
      .tail    (tail_r),
      .tok_in  (tok_chain[g]),
      .tok_out (tok_chain[g+1])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found         = out_found_r;
  assign out_removed_value = out_removed_value_r;

endmodule

`default_nettype wire

/* rtl/lqs_cell.sv */
// one storage slot of the queue with its compare and token stage
`default_nettype none

module lqs_cell
  import lqs_pkg::*;
#(
  parameter int unsigned     AW       = 5,
  parameter logic [AW-1:0]   CELL_IDX = '0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [AW-1:0]     head,
  input  wire logic [AW-1:0]     tail,
  input  wire tok_t              tok_in,
  output tok_t                   tok_out
);

  logic [DATA_W-1:0] word_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              in_range;

  // slot write, decoded locally
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == CELL_IDX)) begin
      word_r <= wr_data;
    end
  end

  assign in_range = (CELL_IDX >= head) && (CELL_IDX <= tail);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld) begin
      if (tok_in.deq) begin
        // head slot hands its word to the token
        if (CELL_IDX == head) begin
          tok_nxt.word = word_r;
          tok_nxt.hit  = 1'b1;
        end
      end else if (in_range && (word_r == tok_in.word)) begin
        tok_nxt.hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench for the linear array queue with search: directed table, then random traffic
`timescale 1ns / 1ps

module testbench
  import lqs_pkg::*;
();

  localparam int unsigned QDEPTH = DEPTH_DEF;
  // the unused fourth operation code, answered with done and no state change
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STEP_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 460;
  localparam int N_ROWS = 25;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic signed [DATA_W-1:0] removed;
  } reply_t;

  // one row of the directed table: operation, word, repeat count (word ramps by
  // one per repeat), and a hand-written reply where one is given
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] word;
    logic [7:0]               reps;
    logic                     by_hand;
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic signed [DATA_W-1:0] removed;
  } row_t;

  localparam row_t DIRECTED [N_ROWS] = '{
    // empty queue after reset
    '{OP_DEQUEUE, 32'h0000_0000, 8'd1, 1'b1, STATUS_EMPTY, 1'b0, 32'h0000_0000},
    '{OP_SEARCH,  32'h0000_0000, 8'd1, 1'b1, STATUS_EMPTY, 1'b0, 32'h0000_0000},
    '{OP_UNUSED,  32'hffff_ffff, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h0000_0000},
    // extremes of the word
    '{OP_ENQUEUE, 32'h7fff_ffff, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_ENQUEUE, 32'h8000_0000, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_SEARCH,  32'h8000_0000, 8'd1, 1'b0, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_SEARCH,  32'h0000_0000, 8'd1, 1'b0, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_DEQUEUE, 32'h0000_0000, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h7fff_ffff},
    // removing the last word sends both positions back to slot 0
    '{OP_DEQUEUE, 32'h0000_0000, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h8000_0000},
    '{OP_ENQUEUE, 32'hffff_ffff, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h0000_0000},
    // value on a dequeue is ignored
    '{OP_DEQUEUE, 32'h5a5a_5a5a, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'hffff_ffff},
    // fill every slot, then one more
    '{OP_ENQUEUE, 32'd100,       8'd32, 1'b0, STATUS_DONE, 1'b0, 32'h0000_0000},
    '{OP_ENQUEUE, 32'd5,         8'd1, 1'b1, STATUS_FULL,  1'b0, 32'h0000_0000},
    '{OP_SEARCH,  32'd131,       8'd1, 1'b0, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_SEARCH,  32'd100,       8'd1, 1'b0, STATUS_DONE,  1'b0, 32'h0000_0000},
    // head moves up to the last slot, tail stays there: still full
    '{OP_DEQUEUE, 32'h0000_0000, 8'd31, 1'b0, STATUS_DONE, 1'b0, 32'h0000_0000},
    '{OP_ENQUEUE, 32'd7,         8'd1, 1'b1, STATUS_FULL,  1'b0, 32'h0000_0000},
    '{OP_SEARCH,  32'd131,       8'd1, 1'b0, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_UNUSED,  32'h7fff_ffff, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_DEQUEUE, 32'h0000_0000, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'd131},
    '{OP_ENQUEUE, 32'h0000_0000, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_SEARCH,  32'h0000_0000, 8'd1, 1'b0, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_DEQUEUE, 32'hffff_ffff, 8'd1, 1'b1, STATUS_DONE,  1'b0, 32'h0000_0000},
    '{OP_DEQUEUE, 32'h0000_0000, 8'd1, 1'b1, STATUS_EMPTY, 1'b0, 32'h0000_0000},
    '{OP_SEARCH,  32'hffff_ffff, 8'd1, 1'b1, STATUS_EMPTY, 1'b0, 32'h0000_0000}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation = OP_ENQUEUE;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic                     out_found;
  logic signed [DATA_W-1:0] out_removed_value;

  // our own copy of the queue contents and positions
  logic signed [DATA_W-1:0] slot_word [QDEPTH];
  int unsigned              head_idx = 0;
  int unsigned              tail_idx = 0;
  bit                       queue_empty = 1'b1;

  reply_t replies_due [$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  linear_queue_with_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_removed_value (out_removed_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // applies one operation to the queue copy and returns the reply it earns
  function automatic reply_t apply_queue_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] word);
    reply_t r;
    r.status  = STATUS_DONE;
    r.found   = 1'b0;
    r.removed = '0;
    case (op)
      OP_ENQUEUE: begin
        if (queue_empty) begin
          // an empty queue always restarts at slot 0
          head_idx     = 0;
          tail_idx     = 0;
          slot_word[0] = word;
          queue_empty  = 1'b0;
        end else if (tail_idx == QDEPTH - 1) begin
          // no wrap: full even when slots below the head are free
          r.status = STATUS_FULL;
        end else begin
          tail_idx            = tail_idx + 1;
          slot_word[tail_idx] = word;
        end
      end
      OP_DEQUEUE: begin
        if (queue_empty) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.removed = slot_word[head_idx];
          if (head_idx >= tail_idx) begin
            head_idx    = 0;
            tail_idx    = 0;
            queue_empty = 1'b1;
          end else begin
            head_idx = head_idx + 1;
          end
        end
      end
      OP_SEARCH: begin
        if (queue_empty) begin
          r.status = STATUS_EMPTY;
        end else begin
          for (int unsigned i = head_idx; i <= tail_idx; i++) begin
            if (slot_word[i] == word) r.found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random word: mostly full range, some small values so searches hit, some extremes
  function automatic logic signed [DATA_W-1:0] pick_word();
    logic signed [DATA_W-1:0] w;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: w = 32'h8000_0000;
          1: w = 32'h7fff_ffff;
          2: w = 32'hffff_ffff;
          default: w = '0;
        endcase
      end
      1, 2, 3: w = $urandom_range(15);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // offers one beat, called at a falling edge, returns at a falling edge;
  // valid stays high into the next call unless that call idles first
  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] word,
                         input bit by_hand, input reply_t hand_reply);
    reply_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_value     = word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // beat taken at this edge: update the queue copy and log the reply
    r = apply_queue_op(op, word);
    replies_due.push_back(by_hand ? hand_reply : r);
    @(negedge clk);
  endtask

  // sender holds off until every reply is back
  task automatic drain_replies();
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  // receiver side: random back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result beats are compared against the oldest reply still due
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with none due: status %0d found %0d removed %0d",
                 $time, out_status, out_found, out_removed_value);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_found);
          error_count++;
        end
        if (out_removed_value !== want.removed) begin
          $display("%0t: removed_value expected %0d actual %0d",
                   $time, want.removed, out_removed_value);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > STEP_LIMIT) begin
      $display("[linear_queue_with_search] ERROR");
      $finish;
    end
  end

  initial begin
    reply_t                   hand;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] word;
    int                       mix;
    int                       pick;
    int                       enq_cut;
    int                       deq_cut;
    int                       srch_cut;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, no idling on either side
    for (int r = 0; r < N_ROWS; r++) begin
      hand.status  = DIRECTED[r].status;
      hand.found   = DIRECTED[r].found;
      hand.removed = DIRECTED[r].removed;
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        send_op(DIRECTED[r].op, DIRECTED[r].word + k, DIRECTED[r].by_hand, hand);
      end
    end
    drain_replies();

    // random traffic in four idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      mix = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // runs of filling, draining and mixed traffic so the tail reaches the
        // last slot and the queue empties often
        if (n % 48 == 0) mix = $urandom_range(2);
        case (mix)
          0: begin enq_cut = 68; deq_cut = 80; srch_cut = 96; end
          1: begin enq_cut = 18; deq_cut = 70; srch_cut = 96; end
          default: begin enq_cut = 36; deq_cut = 70; srch_cut = 96; end
        endcase
        pick = $urandom_range(99);
        if (pick < enq_cut) op = OP_ENQUEUE;
        else if (pick < deq_cut) op = OP_DEQUEUE;
        else if (pick < srch_cut) op = OP_SEARCH;
        else op = OP_UNUSED;

        word = pick_word();
        // half of the searches on a non-empty queue look for a word that is really stored
        if (op == OP_SEARCH && !queue_empty && $urandom_range(1) == 1) begin
          word = slot_word[$urandom_range(tail_idx, head_idx)];
        end

        // now and then the sender waits for the block to go quiet
        if ($urandom_range(199) == 0) drain_replies();
        send_op(op, word, 1'b0, hand);
      end
      drain_replies();
    end

    // let any stray result beat show up
    in_valid = 1'b0;
    repeat (2 * QDEPTH + 8) @(posedge clk);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("[linear_queue_with_search] OK");
    end else begin
      $display("[linear_queue_with_search] ERROR");
    end
    $finish;
  end

endmodule
